// ===== hdl/psi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psi_pkg
// shared types and constants for the pipeline stall interlock
// ----------------------------------------------------------------------------
package psi_pkg;

  // register number width and the implicit stack pointer register
  localparam int unsigned REG_W = 4;
  localparam logic [REG_W-1:0] STACK_REG = 4'h4;

  // opcodes (upper nibble of the first instruction byte)
  localparam logic [3:0] OP_HALT   = 4'h0;
  localparam logic [3:0] OP_RRMOVL = 4'h2;
  localparam logic [3:0] OP_IRMOVL = 4'h3;
  localparam logic [3:0] OP_RMMOVL = 4'h4;
  localparam logic [3:0] OP_MRMOVL = 4'h5;
  localparam logic [3:0] OP_OPL    = 4'h6;
  localparam logic [3:0] OP_JXX    = 4'h7;
  localparam logic [3:0] OP_CALL   = 4'h8;
  localparam logic [3:0] OP_RET    = 4'h9;
  localparam logic [3:0] OP_PUSHL  = 4'hA;
  localparam logic [3:0] OP_POPL   = 4'hB;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_BUBBLES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETURN_BUBBLES = 2'd2;

  typedef enum logic [2:0] {
    CAUSE_NONE    = 3'd0,
    CAUSE_STARTUP = 3'd1,
    CAUSE_JUMP    = 3'd2,
    CAUSE_RETURN  = 3'd3,
    CAUSE_HAZARD  = 3'd4
  } cause_t;

  // one history slot: up to two destination registers
  typedef struct packed {
    logic             v1;
    logic [REG_W-1:0] r1;
    logic             v2;
    logic [REG_W-1:0] r2;
  } slot_t;

  localparam slot_t SLOT_EMPTY = '{v1: 1'b0, r1: '0, v2: 1'b0, r2: '0};

  // source registers the current instruction could read
  typedef struct packed {
    logic [REG_W-1:0] ra;
    logic [REG_W-1:0] rb;
  } query_t;

  // match flags per source
  typedef struct packed {
    logic ra;
    logic rb;
    logic sp;
  } hit_t;

endpackage
`default_nettype wire

// ===== hdl/psi_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psi_in_if / psi_out_if
// valid/ready channels for instruction ticks and stall decisions
// ----------------------------------------------------------------------------
interface psi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] instr_byte;
  logic [7:0] reg_byte;
  logic       fetch_ok;

  modport source (output valid, instr_byte, reg_byte, fetch_ok, input ready);
  modport sink   (input valid, instr_byte, reg_byte, fetch_ok, output ready);
endinterface

interface psi_out_if;
  logic       valid;
  logic       ready;
  logic       proceed;
  logic [2:0] stall_cause;

  modport source (output valid, proceed, stall_cause, input ready);
  modport sink   (input valid, proceed, stall_cause, output ready);
endinterface
`default_nettype wire

// ===== hdl/psi_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psi_cell
// one history slot: holds two destination entries, matches sources, shifts on
// ----------------------------------------------------------------------------
module psi_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           shift_en,
  input  wire psi_pkg::slot_t slot_in,
  input  wire psi_pkg::query_t query,
  output psi_pkg::slot_t      slot_out,
  output psi_pkg::hit_t       hit
);
  import psi_pkg::*;

  slot_t slot_r;

  // valid bits reset, register numbers do not need to
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.v1 <= 1'b0;
      slot_r.v2 <= 1'b0;
    end else if (shift_en) begin
      slot_r <= slot_in;
    end
  end

  always_comb begin
    hit.ra = (slot_r.v1 && slot_r.r1 == query.ra) || (slot_r.v2 && slot_r.r2 == query.ra);
    hit.rb = (slot_r.v1 && slot_r.r1 == query.rb) || (slot_r.v2 && slot_r.r2 == query.rb);
    hit.sp = (slot_r.v1 && slot_r.r1 == STACK_REG) || (slot_r.v2 && slot_r.r2 == STACK_REG);
  end

  assign slot_out = slot_r;

endmodule
`default_nettype wire

// ===== hdl/pipeline_stall_interlock.sv =====
// a decision appears on the out channel in the cycle after its tick transfers
// throughput: one tick per cycle; the input stays ready while the output register
//   is empty or being drained in the same cycle
// reset (rst_n low, synchronous): output register empty, history all empty,
//   startup counter, bubble timer and control stall flag cleared, config registers
//   back to startup 4, jump 2, return 3
`default_nettype none
// ----------------------------------------------------------------------------
// pipeline_stall_interlock
// stall/proceed decision per pipeline tick with a chain of history cells
// ----------------------------------------------------------------------------
module pipeline_stall_interlock #(
  parameter int unsigned HISTORY_DEPTH = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  psi_in_if.sink                                 in_ch,
  psi_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [psi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [psi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import psi_pkg::*;

  // configuration registers
  logic [3:0] startup_ticks_r;
  logic [2:0] jump_bubbles_r;
  logic [2:0] return_bubbles_r;

  // control state
  logic [3:0] tick_cnt_r,  tick_cnt_nxt;
  logic [2:0] timer_r,     timer_nxt;
  logic       ctl_stall_r, ctl_stall_nxt;

  // output register
  logic       out_valid_r;
  logic       out_proceed_r, out_proceed_nxt;
  cause_t     out_cause_r,   out_cause_nxt;

  logic       in_xfer;
  logic       in_startup;
  logic [3:0] op;
  logic [3:0] ra, rb;
  logic       rd_ra, rd_rb, rd_sp;
  logic       is_ctl;
  logic       hazard;
  logic [2:0] load;
  slot_t      new_slot;
  slot_t      shift_slot;
  logic       shift_en;
  query_t     query;
  hit_t       hit_any;

  slot_t      slot_q [HISTORY_DEPTH];
  hit_t       hit_q  [HISTORY_DEPTH];

  // handshake: output register is a single stage that can be drained and
  // refilled in the same cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_ticks_r  <= 4'd4;
      jump_bubbles_r   <= 3'd2;
      return_bubbles_r <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STARTUP_TICKS:  startup_ticks_r  <= cfg_wdata[3:0];
        CFG_JUMP_BUBBLES:   jump_bubbles_r   <= cfg_wdata[2:0];
        CFG_RETURN_BUBBLES: return_bubbles_r <= cfg_wdata[2:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // decode: a failed fetch looks like an instruction with no register use
  // ---------------------------------------------------------------------------
  assign in_startup = tick_cnt_r < startup_ticks_r;
  assign op         = in_ch.fetch_ok ? in_ch.instr_byte[7:4] : OP_HALT;
  assign ra         = in_ch.reg_byte[7:4];
  assign rb         = in_ch.reg_byte[3:0];
  assign is_ctl     = (op == OP_JXX) || (op == OP_RET);
  assign load       = (op == OP_JXX) ? jump_bubbles_r : return_bubbles_r;

  // source registers read and destination slot written, per opcode
  always_comb begin
    rd_ra    = 1'b0;
    rd_rb    = 1'b0;
    rd_sp    = 1'b0;
    new_slot = SLOT_EMPTY;
    case (op)
      OP_RRMOVL: begin
        rd_ra = 1'b1;
        new_slot.v1 = 1'b1;
        new_slot.r1 = rb;
      end
      OP_IRMOVL: begin
        new_slot.v1 = 1'b1;
        new_slot.r1 = rb;
      end
      OP_RMMOVL: begin
        rd_ra = 1'b1;
      end
      OP_MRMOVL: begin
        rd_rb = 1'b1;
        new_slot.v1 = 1'b1;
        new_slot.r1 = ra;
      end
      OP_OPL: begin
        rd_ra = 1'b1;
        rd_rb = 1'b1;
        new_slot.v1 = 1'b1;
        new_slot.r1 = rb;
      end
      OP_CALL: begin
        rd_sp = 1'b1;
        new_slot.v1 = 1'b1;
        new_slot.r1 = STACK_REG;
      end
      OP_PUSHL: begin
        rd_ra = 1'b1;
        rd_sp = 1'b1;
        new_slot.v1 = 1'b1;
        new_slot.r1 = STACK_REG;
      end
      OP_POPL: begin
        rd_sp = 1'b1;
        new_slot.v1 = 1'b1;
        new_slot.r1 = ra;
        new_slot.v2 = 1'b1;
        new_slot.r2 = STACK_REG;
      end
      default: ;  // no register use (return writes nothing either)
    endcase
  end

  // ---------------------------------------------------------------------------
  // history chain: newest slot enters cell 0, every post-startup tick shifts
  // the row by one; the oldest slot falls off the end
  // ---------------------------------------------------------------------------
  assign query.ra = ra;
  assign query.rb = rb;
  assign shift_en = in_xfer && !in_startup;

  genvar g;
  generate
    for (g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
        psi_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .slot_in  (shift_slot),
          .query    (query),
          .slot_out (slot_q[g]),
          .hit      (hit_q[g])
        );
      end else begin : g_body
        psi_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .slot_in  (slot_q[g-1]),
          .query    (query),
          .slot_out (slot_q[g]),
          .hit      (hit_q[g])
        );
      end
    end
  endgenerate

  // combine per-cell matches
  always_comb begin
    hit_any = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      hit_any = hit_any | hit_q[i];
    end
  end

  assign hazard = (rd_ra && hit_any.ra) || (rd_rb && hit_any.rb) || (rd_sp && hit_any.sp);

  // bubble on control ops and data hazards, else the instruction's destinations
  assign shift_slot = (is_ctl || hazard) ? SLOT_EMPTY : new_slot;

  // ---------------------------------------------------------------------------
  // decision and control state next values
  // ---------------------------------------------------------------------------
  always_comb begin
    tick_cnt_nxt    = tick_cnt_r;
    timer_nxt       = timer_r;
    ctl_stall_nxt   = ctl_stall_r;
    out_proceed_nxt = 1'b1;
    out_cause_nxt   = CAUSE_NONE;
    if (in_startup) begin
      // pipeline still filling, nothing else changes
      tick_cnt_nxt    = tick_cnt_r + 4'd1;
      out_proceed_nxt = 1'b0;
      out_cause_nxt   = CAUSE_STARTUP;
    end else if (is_ctl) begin
      if (!ctl_stall_r) begin
        timer_nxt       = load;
        ctl_stall_nxt   = 1'b1;
        out_proceed_nxt = 1'b0;
      end else if (timer_r != 3'd1) begin
        // a zero load wraps to seven here
        timer_nxt       = timer_r - 3'd1;
        out_proceed_nxt = 1'b0;
      end else begin
        timer_nxt       = 3'd0;
        ctl_stall_nxt   = 1'b0;
        out_proceed_nxt = 1'b1;
      end
      if (!out_proceed_nxt) begin
        out_cause_nxt = (op == OP_JXX) ? CAUSE_JUMP : CAUSE_RETURN;
      end
    end else if (hazard) begin
      out_proceed_nxt = 1'b0;
      out_cause_nxt   = CAUSE_HAZARD;
    end
  end

  // control state advances only on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r  <= '0;
      timer_r     <= '0;
      ctl_stall_r <= 1'b0;
    end else if (in_xfer) begin
      tick_cnt_r  <= tick_cnt_nxt;
      timer_r     <= timer_nxt;
      ctl_stall_r <= ctl_stall_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_proceed_r <= out_proceed_nxt;
      out_cause_r   <= out_cause_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.proceed     = out_proceed_r;
  assign out_ch.stall_cause = out_cause_r;

endmodule
`default_nettype wire

// ===== hdl/psi_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psi_checker
// port-level checks for the pipeline stall interlock, bound to the top level
// ----------------------------------------------------------------------------
module psi_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_proceed,
  input wire logic [2:0] out_stall_cause
);
  import psi_pkg::*;

  // a reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a held decision stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_proceed) && $stable(out_stall_cause))
    else $error("stalled decision changed");

  // every accepted tick gives a decision in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("decision missing one cycle after transfer");

  // the input is never blocked while the output register is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output");

  // proceed exactly when there is no stall cause
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_proceed == (out_stall_cause == CAUSE_NONE)))
    else $error("proceed and stall cause disagree");

endmodule

bind pipeline_stall_interlock psi_checker u_psi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_proceed     (out_ch.proceed),
  .out_stall_cause (out_ch.stall_cause)
);
`default_nettype wire
